// ===== rtl/csl_pkg.sv =====
// Shared types, character codes and helpers for the caseless line filter.
`timescale 1ns / 1ps

package csl_pkg;

  localparam logic [7:0] CH_LF = 8'd10;
  localparam logic [7:0] CH_CR = 8'd13;
  localparam logic [7:0] CH_SP = 8'd32;

  localparam int LEN_W        = 6;
  localparam int LINE_W       = 15;
  localparam int COUNT_W      = 16;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 64;
  localparam int PAT_WORDS    = 4;
  localparam int PAT_REG_BYTES = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Configuration register indices
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_3 = 3'd4;

  typedef struct packed {
    logic used;   // cell lies within the active pattern length
    logic eq;     // incoming byte equals its pattern byte
  } cell_stat_t;

  typedef struct packed {
    logic               matched;
    logic [LINE_W-1:0]  length;
    logic [COUNT_W-1:0] count;
  } result_t;

  // ASCII upper case to lower case, all else unchanged
  function automatic logic [7:0] fold_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'd65 && c <= 8'd90) r = c + 8'd32;
    return r;
  endfunction

endpackage

// ===== rtl/csl_cell.sv =====
// One window cell: holds a text byte, compares the arriving byte with its pattern byte.
`timescale 1ns / 1ps

module csl_cell import csl_pkg::*; #(
  parameter int PATTERN_MAX = 32,
  parameter int IDX         = 0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        shift_en,
  input  logic [7:0]                  byte_in,
  input  logic [LEN_W-1:0]            pat_len,
  input  logic [PATTERN_MAX-1:0][7:0] pattern,
  output logic [7:0]                  byte_out,
  output cell_stat_t                  stat
);

  localparam int PW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  logic [7:0]       byte_r;
  logic [LEN_W-1:0] pat_pos;

  // Pattern byte facing this cell sits at len-1-IDX
  assign pat_pos   = pat_len - LEN_W'(1) - LEN_W'(IDX);
  assign stat.used = (LEN_W'(IDX) < pat_len);
  assign stat.eq   = (byte_in == pattern[pat_pos[PW-1:0]]);
  assign byte_out  = byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= '0;
    end else if (shift_en) begin
      byte_r <= byte_in;
    end
  end

endmodule

// ===== rtl/csl_outq.sv =====
// Two-entry result buffer: output register plus skid stage.
`timescale 1ns / 1ps

module csl_outq import csl_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  logic    out_valid_r;
  logic    skid_valid_r;
  result_t out_data_r;
  result_t skid_data_r;
  logic    take;

  assign take      = out_valid_r && !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (take) begin
        out_data_r   <= skid_data_r;
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || take) begin
        out_data_r  <= push_data;
        out_valid_r <= 1'b1;
      end else begin
        skid_data_r  <= push_data;
        skid_valid_r <= 1'b1;
      end
    end else if (take) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule

// ===== rtl/caseless_substring_line_filter_top.sv =====
// Top level of the caseless substring line filter: config, cell chain, line state.
`timescale 1ns / 1ps
//
// Usage
//   Input: one text byte per transfer on in_valid / in_stall / in_data_byte.
//   Each byte other than newline is folded to lower case (carriage return
//   reads as a space) and shifted into a row of PATTERN_MAX cells; each cell
//   compares the byte arriving at it with its pattern byte in the same cycle.
//   Output: one result per newline on out_valid / out_stall with
//   out_line_matched, out_line_length (saturating at LINE_LEN_MAX) and
//   out_match_count (saturating at 65535).
//   Throughput: one byte per cycle when not stalled; the cell row shifts on each
//   accepted byte other than newline, which pushes its result to the output queue.
//   Stall: results queue in the output register and a skid stage; input is
//   stalled only when both hold a result, so text bytes keep flowing while a
//   single result waits.
//   Reset: synchronous, active low; clears the window, line state, count and
//   the pattern registers (pattern length zero matches nothing).
//   Configuration: cfg_we writes register cfg_index; write only while idle.
//
module caseless_substring_line_filter_top import csl_pkg::*; #(
  parameter int PATTERN_MAX  = 32,
  parameter int LINE_LEN_MAX = 16384
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // text input
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_data_byte,
  // results
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_line_matched,
  output logic [LINE_W-1:0]     out_line_length,
  output logic [COUNT_W-1:0]    out_match_count,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam logic [LINE_W-1:0] LINE_SAT = LINE_W'(LINE_LEN_MAX);

  // Configuration registers
  logic [LEN_W-1:0]                      pattern_length_r;
  logic [PAT_WORDS-1:0][CFG_DATA_W-1:0]  pattern_word_r;

  // Line state
  logic [LINE_W-1:0]  bytes_in_line_r, bytes_in_line_nxt;
  logic               line_found_r, line_found_nxt;
  logic [COUNT_W-1:0] matched_lines_r, matched_lines_nxt;

  logic                        accept;
  logic                        is_lf;
  logic                        shift_en;
  logic [7:0]                  folded;
  logic [LEN_W-1:0]            len_eff;
  logic [PATTERN_MAX-1:0][7:0] pattern;
  logic [PATTERN_MAX-1:0][7:0] win;
  logic [PATTERN_MAX-1:0][7:0] cell_in;
  cell_stat_t [PATTERN_MAX-1:0] stat;
  logic [PATTERN_MAX-1:0]      cell_ok;
  logic [LINE_W-1:0]           bytes_inc;
  logic                        hit;
  logic                        outq_full;
  result_t                     res, out_res;

  assign accept   = in_valid && !in_stall;
  assign is_lf    = (in_data_byte == CH_LF);
  assign shift_en = accept && !is_lf;
  assign in_stall = outq_full;

  // Read carriage return as a space, then fold case
  assign folded = fold_lower((in_data_byte == CH_CR) ? CH_SP : in_data_byte);

  // Clamp over-long pattern lengths to the cell count
  assign len_eff = (pattern_length_r > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
                                                          : pattern_length_r;

  // Folded pattern bytes; positions past the registers read as zero
  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_pat
    if (k < PAT_REG_BYTES) begin : g_reg
      assign pattern[k] = fold_lower(pattern_word_r[k / 8][8 * (k % 8) +: 8]);
    end else begin : g_zero
      assign pattern[k] = '0;
    end
  end

  // Row of cells: cell 0 takes the new byte, each cell hands its byte on
  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign cell_in[k] = folded;
    end else begin : g_link
      assign cell_in[k] = win[k-1];
    end

    csl_cell #(
      .PATTERN_MAX (PATTERN_MAX),
      .IDX         (k)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .byte_in  (cell_in[k]),
      .pat_len  (len_eff),
      .pattern  (pattern),
      .byte_out (win[k]),
      .stat     (stat[k])
    );

    assign cell_ok[k] = stat[k].eq || !stat[k].used;
  end

  // Advance the saturating line length, then judge the shifted window
  assign bytes_inc = (bytes_in_line_r < LINE_SAT) ? bytes_in_line_r + LINE_W'(1)
                                                  : bytes_in_line_r;
  assign hit = (len_eff != '0) && (bytes_inc >= LINE_W'(len_eff)) && (&cell_ok);

  always_comb begin
    bytes_in_line_nxt = bytes_in_line_r;
    line_found_nxt    = line_found_r;
    matched_lines_nxt = matched_lines_r;
    if (accept) begin
      if (is_lf) begin
        if (line_found_r && matched_lines_r != COUNT_MAX) begin
          matched_lines_nxt = matched_lines_r + COUNT_W'(1);
        end
        bytes_in_line_nxt = '0;
        line_found_nxt    = 1'b0;
      end else begin
        bytes_in_line_nxt = bytes_inc;
        line_found_nxt    = line_found_r || hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_in_line_r <= '0;
      line_found_r    <= 1'b0;
      matched_lines_r <= '0;
    end else begin
      bytes_in_line_r <= bytes_in_line_nxt;
      line_found_r    <= line_found_nxt;
      matched_lines_r <= matched_lines_nxt;
    end
  end

  // Configuration writes; indices beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_length_r <= '0;
      pattern_word_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PATTERN_LENGTH: pattern_length_r  <= cfg_wdata[LEN_W-1:0];
        REG_PATTERN_WORD_0: pattern_word_r[0] <= cfg_wdata;
        REG_PATTERN_WORD_1: pattern_word_r[1] <= cfg_wdata;
        REG_PATTERN_WORD_2: pattern_word_r[2] <= cfg_wdata;
        REG_PATTERN_WORD_3: pattern_word_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Result of the line just ended; count already includes it
  assign res.matched = line_found_r;
  assign res.length  = bytes_in_line_r;
  assign res.count   = matched_lines_nxt;

  csl_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept && is_lf),
    .push_data (res),
    .full      (outq_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_res)
  );

  assign out_line_matched = out_res.matched;
  assign out_line_length  = out_res.length;
  assign out_match_count  = out_res.count;

`ifndef ASSERT_OFF
  // Skid stage fills only behind a held output register
  a_stall_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty output register");

  // A newline transfer restarts the line
  a_lf_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data_byte == CH_LF) |=>
      (bytes_in_line_r == '0 && !line_found_r))
    else $error("line state not cleared after newline");

  // Matched-line count never goes down
  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (matched_lines_r >= $past(matched_lines_r)))
    else $error("matched line count decreased");
`endif

endmodule
